/* hw/rtl/natural_cubic_spline_coefficients_top_macros.svh */
// assertion macros for the spline coefficient block
`ifndef NATURAL_CUBIC_SPLINE_COEFFICIENTS_TOP_MACROS_SVH
`define NATURAL_CUBIC_SPLINE_COEFFICIENTS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ncs assertion failed");
`define NCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ncs assertion failed");
`else
`define NCS_ASSERT_NOW(lbl, ante, cons)
`define NCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ncs_pkg.sv */
// shared constants, command and status types of the spline coefficient block
package ncs_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_VALUE_WIDTH  = 32;
  localparam int WORK_W  = 64;
  localparam int MAG_W   = 63;
  localparam int FRAC_W  = 16;
  localparam int DIV_W   = 31;
  localparam int ADDR_W  = 7;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W = 7;

  localparam logic CFG_GRID_STEP     = 1'b0;
  localparam logic CFG_SEGMENT_COUNT = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LD_YA,
    OP_LD_YB,
    OP_SW_R,
    OP_SW_N,
    OP_SW_P,
    OP_SW_Q,
    OP_BK_LD,
    OP_BK_M,
    OP_OUT_LD,
    OP_OUT_ARG,
    OP_CH_LD,
    OP_CH_STEP,
    OP_CH_FIN,
    OP_PUB,
    OP_OUT_NEXT
  } op_t;

  typedef enum logic [1:0] {
    DSRC_ONE,
    DSRC_NUM,
    DSRC_CHAIN
  } div_src_t;

  typedef enum logic [1:0] {
    CH_B,
    CH_C,
    CH_D
  } chain_t;

  typedef struct packed {
    op_t               op;
    logic              s_we;
    logic [ADDR_W-1:0] s_addr;
    logic [ADDR_W-1:0] c_rd_addr;
    logic [ADDR_W-1:0] c_wr_addr;
    logic              div_start;
    div_src_t          div_src;
    chain_t            chain;
    logic [ADDR_W-1:0] idx;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic mul_done;
    logic out_valid;
    logic out_xfer;
  } st_t;

endpackage

/* hw/rtl/natural_cubic_spline_coefficients_top.sv */
// Natural cubic spline coefficient block: takes n+1 Q16.16 samples on a
// uniform grid and returns one set of coefficients a, b, c, d per segment.
// Configuration: cfg_we/cfg_index/cfg_data write grid_step (index 0) or
// segment_count (index 1); write only while no run is in progress.
// Input: in_valid/in_ready transfers one sample per cycle while loading.
// The transfer that completes sample n starts the solve; in_ready stays
// low until the last segment result of the run has been taken.
// Output: out_valid/out_ready, one transfer per segment, in order,
// out_last_segment marks segment n.
// Timing is set by the shared serial divider (79 steps) and the 16-step
// shift-add multiplier: two divisions per forward sweep step, one
// multiplication per back pass step and six divisions per segment output.
// A stalled receiver holds the sequencer in its wait state; nothing is lost.
// Reset (rst_n low, synchronous) empties the sample count, drops out_valid
// and restores grid_step to 1.0 and segment_count to 8.
module natural_cubic_spline_coefficients_top #(
  parameter int MAX_SEGMENTS = ncs_pkg::DEF_MAX_SEGMENTS,
  parameter int VALUE_WIDTH  = ncs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ncs_pkg::DIV_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ncs_pkg::SAMPLE_W-1:0] in_sample_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ncs_pkg::COUNT_W-1:0]  out_segment_index,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_constant,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_linear,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_quadratic,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_cubic,
  output logic                         out_last_segment,
  output logic                         out_saturated
);
  import ncs_pkg::*;

  logic [DIV_W-1:0]   grid_step_r, grid_eff;
  logic [COUNT_W-1:0] seg_count_r;
  logic [ADDR_W-1:0]  n_eff;
  cmd_t               cmd;
  st_t                st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_step_r <= DIV_W'(65536);
      seg_count_r <= COUNT_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_STEP:     grid_step_r <= cfg_data;
        CFG_SEGMENT_COUNT: seg_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero step acts as the smallest step, count clamped to 1..MAX_SEGMENTS
  always_comb begin
    grid_eff = (grid_step_r == '0) ? DIV_W'(1) : grid_step_r;
    if (seg_count_r == '0) n_eff = ADDR_W'(1);
    else if (seg_count_r > COUNT_W'(MAX_SEGMENTS)) n_eff = ADDR_W'(MAX_SEGMENTS);
    else n_eff = ADDR_W'(seg_count_r);
  end

  ncs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .n_eff    (n_eff),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ncs_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_sample_value    (in_sample_value),
    .grid               (grid_eff),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_segment_index  (out_segment_index),
    .out_coef_constant  (out_coef_constant),
    .out_coef_linear    (out_coef_linear),
    .out_coef_quadratic (out_coef_quadratic),
    .out_coef_cubic     (out_coef_cubic),
    .out_last_segment   (out_last_segment),
    .out_saturated      (out_saturated)
  );

endmodule

/* hw/rtl/ncs_div.sv */
// serial restoring divider: floor(mag * 2^16 / divisor), held at 2^62
module ncs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ncs_pkg::MAG_W-1:0] dividend_mag,
  input  logic [ncs_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [ncs_pkg::MAG_W-1:0] quot
);
  import ncs_pkg::*;

  localparam int DW = MAG_W + FRAC_W;
  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    d_r, d_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt, dv_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [MAG_W-1:0] quot_r;
  logic [DIV_W:0]   rem_s, diff;
  logic             ge;

  always_comb begin
    rem_s   = {rem_r, d_r[DW-1]};
    diff    = rem_s - {1'b0, dv_r};
    ge      = rem_s >= {1'b0, dv_r};
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_s[DIV_W-1:0];
    d_nxt   = {d_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        d_r    <= {dividend_mag, {FRAC_W{1'b0}}};
        rem_r  <= '0;
        dv_r   <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        d_r   <= d_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          // quotient at or above 2^62 is held there
          if (|d_nxt[DW-1:MAG_W-1]) quot_r <= {1'b1, {(MAG_W-1){1'b0}}};
          else quot_r <= d_nxt[MAG_W-1:0];
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/ncs_dp.sv */
// datapath: sample and sweep memories, working registers, multiplier, divider, result register
module ncs_dp #(
  parameter int MAX_SEGMENTS = ncs_pkg::DEF_MAX_SEGMENTS,
  parameter int VALUE_WIDTH  = ncs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ncs_pkg::cmd_t                cmd,
  output ncs_pkg::st_t                 st,
  input  logic [ncs_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [ncs_pkg::DIV_W-1:0]    grid,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ncs_pkg::COUNT_W-1:0]  out_segment_index,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_constant,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_linear,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_quadratic,
  output logic [ncs_pkg::SAMPLE_W-1:0] out_coef_cubic,
  output logic                         out_last_segment,
  output logic                         out_saturated
);
  import ncs_pkg::*;

  localparam int SDEPTH = MAX_SEGMENTS + 1;
  localparam int CDEPTH = MAX_SEGMENTS + 2;
  localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CAW = $clog2(CDEPTH);
  localparam int PM_W = 16;
  localparam int MC_W = $clog2(PM_W);

  typedef logic signed [WORK_W-1:0] wv_t;

  function automatic logic [MAG_W-1:0] mag_of(input wv_t v);
    wv_t a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic wv_t signed_of(input logic [MAG_W-1:0] m, input logic neg);
    wv_t a;
    a = wv_t'({1'b0, m});
    return neg ? -a : a;
  endfunction

  // {clipped flag, low 32 bits}
  function automatic logic [SAMPLE_W:0] clip_val(input wv_t v);
    wv_t hi, lo, c;
    logic sat;
    hi = wv_t'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    lo = -hi - wv_t'(1);
    sat = 1'b0;
    c = v;
    if (v > hi) begin
      c = hi;
      sat = 1'b1;
    end
    if (v < lo) begin
      c = lo;
      sat = 1'b1;
    end
    return {sat, c[SAMPLE_W-1:0]};
  endfunction

  logic signed [SAMPLE_W-1:0] smem [SDEPTH];
  wv_t pmem [CDEPTH];
  wv_t qmem [CDEPTH];
  wv_t mmem [CDEPTH];

  logic signed [SAMPLE_W-1:0] rd_y_r;
  wv_t rd_p_r, rd_q_r, rd_m_r;

  wv_t ya_r, yb_r, yk_r, acc_r, num_r, pr_r, qr_r, m0_r, m1_r, qk_r;
  wv_t argb_r, argc_r, argd_r;
  logic [DIV_W-1:0] den_r;
  logic [MAG_W-1:0] cmag_r;
  logic             cneg_r;

  logic [PM_W-1:0]   mplier_r;
  wv_t               mcand_r, macc_r;
  logic [MC_W-1:0]   mcnt_r;
  logic              mbusy_r, mdone_r, psign_r;

  logic                out_valid_r, out_last_r, sat_r;
  logic [COUNT_W-1:0]  out_idx_r;
  logic [SAMPLE_W-1:0] oa_r, ob_r, oc_r, od_r;

  logic [MAG_W-1:0] div_mag;
  logic [DIV_W-1:0] div_dv;
  logic             div_busy, div_done;
  logic [MAG_W-1:0] quot;

  wv_t rd_y_w, quot_w, fin_w, prod_sh, p_mag;
  logic [SAMPLE_W:0] clip_fin, clip_a;
  logic [CAW-1:0] c_rd, c_wr;
  logic [SAW-1:0] s_ad;

  assign rd_y_w  = wv_t'(rd_y_r);
  assign quot_w  = wv_t'({1'b0, quot});
  assign fin_w   = signed_of(cmag_r, cneg_r);
  assign clip_fin = clip_val(fin_w);
  assign clip_a   = clip_val(ya_r);
  assign prod_sh = signed_of(MAG_W'(macc_r[WORK_W-1:FRAC_W]), psign_r);
  assign p_mag   = (rd_p_r < 0) ? -rd_p_r : rd_p_r;
  assign c_rd = cmd.c_rd_addr[CAW-1:0];
  assign c_wr = cmd.c_wr_addr[CAW-1:0];
  assign s_ad = cmd.s_addr[SAW-1:0];

  always_comb begin
    case (cmd.div_src)
      DSRC_ONE: begin
        div_mag = MAG_W'(64'd65536);
        div_dv  = den_r;
      end
      DSRC_NUM: begin
        div_mag = mag_of(num_r);
        div_dv  = den_r;
      end
      DSRC_CHAIN: begin
        div_mag = cmag_r;
        div_dv  = grid;
      end
      default: begin
        div_mag = cmag_r;
        div_dv  = grid;
      end
    endcase
  end

  ncs_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (cmd.div_start),
    .dividend_mag (div_mag),
    .divisor      (div_dv),
    .busy         (div_busy),
    .done         (div_done),
    .quot         (quot)
  );

  // memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.s_we) smem[s_ad] <= in_sample_value;
    rd_y_r <= smem[s_ad];
    if (cmd.op == OP_SW_P) pmem[c_wr] <= -quot_w;
    if (cmd.op == OP_SW_Q) qmem[c_wr] <= num_r[WORK_W-1] ? -quot_w : quot_w;
    if (cmd.op == OP_BK_M) mmem[c_wr] <= prod_sh + qk_r;
    rd_p_r <= pmem[c_rd];
    rd_q_r <= qmem[c_rd];
    rd_m_r <= mmem[c_rd];
  end

  // serial shift-add multiplier for the back pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.op == OP_BK_LD) begin
        mplier_r <= p_mag[PM_W-1:0];
        mcand_r  <= (m0_r < 0) ? -m0_r : m0_r;
        psign_r  <= (rd_p_r < 0) ^ (m0_r < 0);
        macc_r   <= '0;
        mcnt_r   <= '0;
        qk_r     <= rd_q_r;
        mbusy_r  <= 1'b1;
      end else if (mbusy_r) begin
        if (mplier_r[0]) macc_r <= macc_r + mcand_r;
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        mcnt_r   <= mcnt_r + MC_W'(1);
        if (mcnt_r == MC_W'(PM_W - 1)) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLR: begin
          pr_r <= '0;
          qr_r <= '0;
          m0_r <= '0;
        end
        OP_LD_YA: ya_r <= rd_y_w;
        OP_LD_YB: yb_r <= rd_y_w;
        OP_SW_R: begin
          yk_r  <= rd_y_w;
          acc_r <= rd_y_w + ya_r - (yb_r <<< 1);
        end
        OP_SW_N: begin
          num_r <= acc_r - qr_r;
          den_r <= DIV_W'(wv_t'(64'sd262144) + pr_r);
        end
        OP_SW_P: pr_r <= -quot_w;
        OP_SW_Q: begin
          qr_r <= num_r[WORK_W-1] ? -quot_w : quot_w;
          ya_r <= yb_r;
          yb_r <= yk_r;
        end
        OP_BK_M: m0_r <= prod_sh + qk_r;
        OP_OUT_LD: begin
          yk_r <= rd_y_w;
          m1_r <= cmd.last ? '0 : rd_m_r;
        end
        OP_OUT_ARG: begin
          argb_r <= (yk_r - ya_r) - (m1_r + (m0_r <<< 1));
          argc_r <= m0_r + (m0_r <<< 1);
          argd_r <= m1_r - m0_r;
          oa_r   <= clip_a[SAMPLE_W-1:0];
          sat_r  <= clip_a[SAMPLE_W];
        end
        OP_CH_LD: begin
          case (cmd.chain)
            CH_B: begin
              cmag_r <= mag_of(argb_r);
              cneg_r <= argb_r < 0;
            end
            CH_C: begin
              cmag_r <= mag_of(argc_r);
              cneg_r <= argc_r < 0;
            end
            default: begin
              cmag_r <= mag_of(argd_r);
              cneg_r <= argd_r < 0;
            end
          endcase
        end
        OP_CH_STEP: cmag_r <= quot;
        OP_CH_FIN: begin
          sat_r <= sat_r | clip_fin[SAMPLE_W];
          case (cmd.chain)
            CH_B: ob_r <= clip_fin[SAMPLE_W-1:0];
            CH_C: oc_r <= clip_fin[SAMPLE_W-1:0];
            default: od_r <= clip_fin[SAMPLE_W-1:0];
          endcase
        end
        OP_PUB: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= COUNT_W'(cmd.idx);
          out_last_r  <= cmd.last;
        end
        OP_OUT_NEXT: begin
          ya_r <= yk_r;
          m0_r <= m1_r;
        end
        default: ;
      endcase
    end
  end

  assign st.div_busy  = div_busy;
  assign st.div_done  = div_done;
  assign st.mul_done  = mdone_r;
  assign st.out_valid = out_valid_r;
  assign st.out_xfer  = out_valid_r & out_ready;

  assign out_valid          = out_valid_r;
  assign out_segment_index  = out_idx_r;
  assign out_coef_constant  = oa_r;
  assign out_coef_linear    = ob_r;
  assign out_coef_quadratic = oc_r;
  assign out_coef_cubic     = od_r;
  assign out_last_segment   = out_last_r;
  assign out_saturated      = sat_r;

endmodule

/* hw/rtl/ncs_ctrl.sv */
// sequencer: load, forward sweep, back pass and per-segment output
`include "natural_cubic_spline_coefficients_top_macros.svh"
module ncs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ncs_pkg::ADDR_W-1:0] n_eff,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ncs_pkg::st_t               st,
  output ncs_pkg::cmd_t              cmd
);
  import ncs_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT_A, S_INIT_B, S_INIT_C,
    S_SW_RD, S_SW_Y, S_SW_N, S_SW_D1, S_SW_W1, S_SW_D2, S_SW_W2,
    S_BK_RD, S_BK_LD, S_BK_W,
    S_OUT_A, S_OUT_B, S_OUT_RD, S_OUT_LD, S_OUT_ARG,
    S_CH_LD, S_CH_S, S_CH_W, S_CH_FIN, S_PUB, S_WAIT
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] loaded_r, idx_r;
  chain_t            chain_r;
  logic [1:0]        ccnt_r;
  logic              in_xfer;

  assign in_ready = (state_r == S_LOAD);
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.div_src   = DSRC_CHAIN;
    cmd.chain     = chain_r;
    cmd.idx       = idx_r;
    cmd.last      = (idx_r == n_eff);
    cmd.s_addr    = idx_r;
    cmd.c_rd_addr = idx_r + ADDR_W'(1);
    cmd.c_wr_addr = idx_r + ADDR_W'(1);
    case (state_r)
      S_LOAD: begin
        cmd.s_addr = loaded_r;
        cmd.s_we   = in_valid;
      end
      S_INIT_A: begin
        cmd.s_addr = '0;
        cmd.op     = OP_CLR;
      end
      S_INIT_B: begin
        cmd.s_addr = ADDR_W'(1);
        cmd.op     = OP_LD_YA;
      end
      S_INIT_C: cmd.op = OP_LD_YB;
      S_SW_Y:   cmd.op = OP_SW_R;
      S_SW_N:   cmd.op = OP_SW_N;
      S_SW_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_ONE;
      end
      S_SW_W1:  if (st.div_done) cmd.op = OP_SW_P;
      S_SW_D2: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DSRC_NUM;
      end
      S_SW_W2:  if (st.div_done) cmd.op = OP_SW_Q;
      S_BK_LD:  cmd.op = OP_BK_LD;
      S_BK_W: begin
        cmd.c_wr_addr = idx_r;
        if (st.mul_done) cmd.op = OP_BK_M;
      end
      S_OUT_A: begin
        cmd.s_addr = '0;
        cmd.op     = OP_CLR;
      end
      S_OUT_B:   cmd.op = OP_LD_YA;
      S_OUT_LD:  cmd.op = OP_OUT_LD;
      S_OUT_ARG: cmd.op = OP_OUT_ARG;
      S_CH_LD:   cmd.op = OP_CH_LD;
      S_CH_S:    cmd.div_start = 1'b1;
      S_CH_W:    if (st.div_done) cmd.op = OP_CH_STEP;
      S_CH_FIN:  cmd.op = OP_CH_FIN;
      S_PUB:     cmd.op = OP_PUB;
      S_WAIT:    if (st.out_xfer) cmd.op = OP_OUT_NEXT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      loaded_r <= '0;
      idx_r    <= '0;
      chain_r  <= CH_B;
      ccnt_r   <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            // run starts once n+1 samples are held
            if (loaded_r >= n_eff) begin
              loaded_r <= '0;
              state_r  <= S_INIT_A;
            end else begin
              loaded_r <= loaded_r + ADDR_W'(1);
            end
          end
        end
        S_INIT_A: state_r <= S_INIT_B;
        S_INIT_B: state_r <= S_INIT_C;
        S_INIT_C: begin
          if (n_eff < ADDR_W'(2)) begin
            idx_r   <= ADDR_W'(1);
            state_r <= S_OUT_A;
          end else begin
            idx_r   <= ADDR_W'(2);
            state_r <= S_SW_RD;
          end
        end
        S_SW_RD: state_r <= S_SW_Y;
        S_SW_Y:  state_r <= S_SW_N;
        S_SW_N:  state_r <= S_SW_D1;
        S_SW_D1: state_r <= S_SW_W1;
        S_SW_W1: if (st.div_done) state_r <= S_SW_D2;
        S_SW_D2: state_r <= S_SW_W2;
        S_SW_W2: begin
          if (st.div_done) begin
            if (idx_r == n_eff) begin
              state_r <= S_BK_RD;
            end else begin
              idx_r   <= idx_r + ADDR_W'(1);
              state_r <= S_SW_RD;
            end
          end
        end
        S_BK_RD: state_r <= S_BK_LD;
        S_BK_LD: state_r <= S_BK_W;
        S_BK_W: begin
          if (st.mul_done) begin
            if (idx_r == ADDR_W'(2)) begin
              idx_r   <= ADDR_W'(1);
              state_r <= S_OUT_A;
            end else begin
              idx_r   <= idx_r - ADDR_W'(1);
              state_r <= S_BK_RD;
            end
          end
        end
        S_OUT_A:  state_r <= S_OUT_B;
        S_OUT_B:  state_r <= S_OUT_RD;
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: state_r <= S_OUT_ARG;
        S_OUT_ARG: begin
          chain_r <= CH_B;
          ccnt_r  <= 2'd1;
          state_r <= S_CH_LD;
        end
        S_CH_LD: state_r <= S_CH_S;
        S_CH_S:  state_r <= S_CH_W;
        S_CH_W: begin
          if (st.div_done) begin
            if (ccnt_r == 2'd1) begin
              state_r <= S_CH_FIN;
            end else begin
              ccnt_r  <= ccnt_r - 2'd1;
              state_r <= S_CH_S;
            end
          end
        end
        S_CH_FIN: begin
          case (chain_r)
            CH_B: begin
              chain_r <= CH_C;
              ccnt_r  <= 2'd2;
              state_r <= S_CH_LD;
            end
            CH_C: begin
              chain_r <= CH_D;
              ccnt_r  <= 2'd3;
              state_r <= S_CH_LD;
            end
            default: state_r <= S_PUB;
          endcase
        end
        S_PUB: state_r <= S_WAIT;
        S_WAIT: begin
          if (st.out_xfer) begin
            if (idx_r == n_eff) begin
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + ADDR_W'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  `NCS_ASSERT_NOW(a_no_load_while_out, st.out_valid, !in_ready)
  `NCS_ASSERT_NOW(a_div_start_idle, cmd.div_start, !st.div_busy)
  `NCS_ASSERT_NEXT(a_run_blocks_input, in_xfer && (loaded_r >= n_eff), !in_ready)

endmodule
